// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the reranking block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, clocked on clk and held off while rst is high.
`define RRK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that only applies in cycles where the enable is high.
`define RRK_ASSERT_ON(label, en, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (en) |-> (prop)) else $error(msg);

`endif

// File: hdl/rrk_pkg.sv
// Shared constants and types of the dot-product reranking block.
package rrk_pkg;

  // Field and datapath widths.
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SCORE_W = 41;
  localparam int POS_W   = 24;
  localparam int DOC_W   = 25;
  localparam int PLACE_W = 4;

  // Length of the ranked list.
  localparam int TOP_K = 10;

  // Reset value of the document count register.
  localparam logic [DOC_W-1:0] DOC_COUNT_RESET = DOC_W'(25'h100_0000);

  // Saturation limits of the running dot product.
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // One entry of the ranked list.
  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic        [POS_W-1:0]   rank;
    logic        [POS_W-1:0]   pos;
  } entry_t;

  // One slot of the result row.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } slot_t;

endpackage

// File: hdl/rrk_cell.sv
// One place of the sorted candidate list, with its insert decision.
module rrk_cell import rrk_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t cand,
  input  logic   ins,
  input  logic   clear,
  input  entry_t prev_entry,
  input  logic   prev_beats,
  output entry_t entry,
  output entry_t entry_next,
  output logic   beats
);

  // The candidate beats an empty place, a lower score, or an equal score with a larger rank.
  always_comb begin
    beats = !entry.valid
         || ($signed(cand.score) > $signed(entry.score))
         || (($signed(cand.score) == $signed(entry.score)) && (cand.rank < entry.rank));
  end

  // Contents after the insert: the neighbour shifts down, the candidate lands, or we keep.
  always_comb begin
    entry_next = entry;
    if (ins) begin
      if (prev_beats) begin
        entry_next = prev_entry;
      end else if (beats) begin
        entry_next = cand;
        entry_next.valid = 1'b1;
      end
    end
  end

  // Valid bit, cleared by reset and at the end of each pool.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (clear) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

  // Payload of the place.
  always_ff @(posedge clk) begin
    entry.score <= entry_next.score;
    entry.rank  <= entry_next.rank;
    entry.pos   <= entry_next.pos;
  end

endmodule

// File: hdl/rrk_out_cell.sv
// One slot of the result row, loaded at pool end and shifted towards the output.
module rrk_out_cell import rrk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  slot_t load_slot,
  input  logic  shift,
  input  slot_t nxt_slot,
  output slot_t slot
);

  // Valid bit of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot.valid <= load_slot.valid;
    end else if (shift) begin
      slot.valid <= nxt_slot.valid;
    end
  end

  // Position held in the slot.
  always_ff @(posedge clk) begin
    if (load) begin
      slot.pos <= load_slot.pos;
    end else if (shift) begin
      slot.pos <= nxt_slot.pos;
    end
  end

endmodule

// File: hdl/dot_product_top_k_rerank.sv
// Top level of the dot-product reranking block.
// A candidate's last element passes the stage-1 and stage-2 registers, then enters the list;
// a pool's last item passes the same registers before its results load into the result row.
// Throughput: one item in, and while rank_stall is low one result out, per cycle; the input
// stalls only while a pool end waits for the row to hold nothing beyond the result being taken.
// Reset (rst, synchronous) clears sum, list, error flag and row; document count 16777216.
module dot_product_top_k_rerank import rrk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [DOC_W-1:0]         cfg_data,
  input  logic                     cand_valid,
  output logic                     cand_stall,
  input  logic signed [ELEM_W-1:0] doc_element,
  input  logic signed [ELEM_W-1:0] query_element,
  input  logic [POS_W-1:0]         candidate_position,
  input  logic [POS_W-1:0]         tie_rank,
  input  logic                     last_dimension,
  input  logic                     last_candidate,
  output logic                     rank_valid,
  input  logic                     rank_stall,
  output logic [POS_W-1:0]         ranked_position,
  output logic [PLACE_W-1:0]       place,
  output logic                     is_last,
  output logic                     bad_position
);

  logic [DOC_W-1:0] num_docs;

  logic                      s1_valid;
  logic signed [PROD_W-1:0]  s1_prod;
  logic [POS_W-1:0]          s1_pos;
  logic [POS_W-1:0]          s1_rank;
  logic                      s1_last_dim;
  logic                      s1_last_cand;
  logic                      s1_bad;

  logic signed [SCORE_W-1:0] partial_sum;
  logic signed [SCORE_W:0]   sum_wide;
  logic signed [SCORE_W-1:0] sum_sat;

  logic                      s2_valid;
  logic signed [SCORE_W-1:0] s2_score;
  logic [POS_W-1:0]          s2_pos;
  logic [POS_W-1:0]          s2_rank;
  logic                      s2_end;
  logic                      s2_bad;

  logic   adv;
  logic   fire;
  logic   ins;
  logic   pool_end;
  logic   error_seen;
  logic   err;
  logic   take;
  logic   load_ok;
  entry_t cand;

  entry_t             cell_entry [TOP_K];
  entry_t             cell_next  [TOP_K];
  logic [TOP_K-1:0]   cell_beats;
  slot_t              load_slot  [TOP_K];
  slot_t              out_slot   [TOP_K+1];
  logic [PLACE_W-1:0] out_place;
  logic               out_bad;

  // Document count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_docs <= DOC_COUNT_RESET;
    end else if (cfg_we) begin
      num_docs <= cfg_data;
    end
  end

  // The whole pipeline moves unless a pool end waits for room in the result row.
  assign take    = out_slot[0].valid && !rank_stall;
  assign load_ok = !out_slot[0].valid || (take && !out_slot[1].valid);
  assign adv     = !(s2_valid && s2_end && !load_ok);
  assign cand_stall = !adv;

  // Stage 1: product of the two elements and the position check.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod      <= doc_element * query_element;
      s1_pos       <= candidate_position;
      s1_rank      <= tie_rank;
      s1_last_dim  <= last_dimension;
      s1_last_cand <= last_candidate;
      s1_bad       <= ({1'b0, candidate_position} >= num_docs);
    end
  end

  // Stage 2: saturating accumulation of the dot product.
  always_comb begin
    sum_wide = {partial_sum[SCORE_W-1], partial_sum}
             + {{(SCORE_W + 1 - PROD_W){s1_prod[PROD_W-1]}}, s1_prod};
    case (sum_wide[SCORE_W:SCORE_W-1])
      2'b01:   sum_sat = SCORE_MAX;
      2'b10:   sum_sat = SCORE_MIN;
      default: sum_sat = sum_wide[SCORE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
      s2_valid    <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_last_dim;
      if (s1_valid) begin
        partial_sum <= s1_last_dim ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_score <= sum_sat;
      s2_pos   <= s1_pos;
      s2_rank  <= s1_rank;
      s2_end   <= s1_last_cand;
      s2_bad   <= s1_bad;
    end
  end

  // A finished candidate goes into the list unless its position is bad.
  assign fire     = s2_valid && adv;
  assign ins      = fire && !s2_bad;
  assign pool_end = fire && s2_end;
  assign err      = error_seen || s2_bad;

  always_comb begin
    cand.valid = 1'b1;
    cand.score = s2_score;
    cand.rank  = s2_rank;
    cand.pos   = s2_pos;
  end

  // Error flag of the current pool.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
    end else if (pool_end) begin
      error_seen <= 1'b0;
    end else if (fire && s2_bad) begin
      error_seen <= 1'b1;
    end
  end

  // Row of list places; each takes its neighbour above when the candidate lands higher.
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    if (i == 0) begin : g_head
      rrk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cand       (cand),
        .ins        (ins),
        .clear      (pool_end),
        .prev_entry (cand),
        .prev_beats (1'b0),
        .entry      (cell_entry[i]),
        .entry_next (cell_next[i]),
        .beats      (cell_beats[i])
      );
    end else begin : g_body
      rrk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cand       (cand),
        .ins        (ins),
        .clear      (pool_end),
        .prev_entry (cell_entry[i-1]),
        .prev_beats (cell_beats[i-1]),
        .entry      (cell_entry[i]),
        .entry_next (cell_next[i]),
        .beats      (cell_beats[i])
      );
    end

    // At pool end the row receives the finished list, or one error item in the first slot.
    always_comb begin
      if (err) begin
        load_slot[i].valid = (i == 0);
        load_slot[i].pos   = '0;
      end else begin
        load_slot[i].valid = cell_next[i].valid;
        load_slot[i].pos   = cell_next[i].pos;
      end
    end

    rrk_out_cell u_out_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (pool_end),
      .load_slot (load_slot[i]),
      .shift     (take),
      .nxt_slot  (out_slot[i+1]),
      .slot      (out_slot[i])
    );
  end

  // Nothing follows the last slot.
  assign out_slot[TOP_K] = '0;

  // Place counter and error flag of the results being delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_place <= '0;
      out_bad   <= 1'b0;
    end else if (pool_end) begin
      out_place <= '0;
      out_bad   <= err;
    end else if (take) begin
      out_place <= out_place + PLACE_W'(1);
    end
  end

  // Result item.
  assign rank_valid      = out_slot[0].valid;
  assign ranked_position = out_slot[0].pos;
  assign place           = out_place;
  assign is_last         = !out_slot[1].valid;
  assign bad_position    = out_bad;

endmodule

// File: hdl/rrk_checker.sv
// Port-level checks of the reranking block and their binding to the top level.
`include "assert_macros.svh"

module rrk_checker import rrk_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rank_valid,
  input logic               rank_stall,
  input logic [POS_W-1:0]   ranked_position,
  input logic [PLACE_W-1:0] place,
  input logic               is_last,
  input logic               bad_position
);

  // An error report is a single item at the first place with no position.
  `RRK_ASSERT_ON(a_error_item, rank_valid && bad_position,
    is_last && (place == '0) && (ranked_position == '0), "error item malformed")

  // Places stay inside the list length.
  `RRK_ASSERT_ON(a_place_range, rank_valid, place < PLACE_W'(TOP_K), "place out of range")

  // A taken item that is not the last is followed at once by the next place.
  `RRK_ASSERT(a_next_place,
    (rank_valid && !rank_stall && !is_last) |=>
      (rank_valid && (place == $past(place) + PLACE_W'(1))),
    "ranking broken off before its last item")

  // A stalled result item stays offered.
  `RRK_ASSERT(a_hold, (rank_valid && rank_stall) |=> rank_valid, "result item withdrawn")

endmodule

bind dot_product_top_k_rerank rrk_checker u_rrk_checker (
  .clk             (clk),
  .rst             (rst),
  .rank_valid      (rank_valid),
  .rank_stall      (rank_stall),
  .ranked_position (ranked_position),
  .place           (place),
  .is_last         (is_last),
  .bad_position    (bad_position)
);

// File: sim/tb_top.sv
// Self-checking testbench for the dot-product top-ten reranking block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrk_pkg::*;

  // One vector element of a candidate, as presented on the input channel.
  typedef struct {
    logic signed [ELEM_W-1:0] doc;
    logic signed [ELEM_W-1:0] query;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         rank;
    logic                     last_dim;
    logic                     last_cand;
  } elem_item_t;

  // One ranking result.
  typedef struct {
    logic [POS_W-1:0]   pos;
    logic [PLACE_W-1:0] place;
    logic               last;
    logic               bad;
  } ranked_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DOC_W-1:0] cfg_data = '0;
  logic cand_valid = 1'b0;
  logic cand_stall;
  logic signed [ELEM_W-1:0] doc_element = '0;
  logic signed [ELEM_W-1:0] query_element = '0;
  logic [POS_W-1:0] candidate_position = '0;
  logic [POS_W-1:0] tie_rank = '0;
  logic last_dimension = 1'b0;
  logic last_candidate = 1'b0;
  logic rank_valid;
  logic rank_stall = 1'b0;
  logic [POS_W-1:0] ranked_position;
  logic [PLACE_W-1:0] place;
  logic is_last;
  logic bad_position;

  dot_product_top_k_rerank i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .cand_valid         (cand_valid),
    .cand_stall         (cand_stall),
    .doc_element        (doc_element),
    .query_element      (query_element),
    .candidate_position (candidate_position),
    .tie_rank           (tie_rank),
    .last_dimension     (last_dimension),
    .last_candidate     (last_candidate),
    .rank_valid         (rank_valid),
    .rank_stall         (rank_stall),
    .ranked_position    (ranked_position),
    .place              (place),
    .is_last            (is_last),
    .bad_position       (bad_position)
  );

  always #10 clk = ~clk;

  // Items waiting to be sent and rankings still owed by the block.
  elem_item_t pending[$];
  ranked_t    ranks_due[$];
  elem_item_t bus_item;

  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int pools_closed = 0;
  int pools_bad = 0;
  int config_writes = 0;
  int errors = 0;
  int calm_send = 0;
  int calm_recv = 0;
  int send_gap = 0;
  int stall_left = 0;

  // Predictor state: running dot product, the sorted best list and the error flag.
  logic signed [SCORE_W-1:0] run_sum = '0;
  logic signed [SCORE_W-1:0] top_score [TOP_K];
  logic [POS_W-1:0]          top_pos [TOP_K];
  logic [POS_W-1:0]          top_rank [TOP_K];
  int                        top_fill = 0;
  bit                        pool_error = 1'b0;
  logic [DOC_W-1:0]          doc_limit = DOC_COUNT_RESET;

  // Empty the best list and the running sum at the end of a pool.
  function automatic void clear_pool();
    run_sum = '0;
    for (int i = 0; i < TOP_K; i++) begin
      top_score[i] = '0;
      top_pos[i] = '0;
      top_rank[i] = '0;
    end
    top_fill = 0;
    pool_error = 1'b0;
  endfunction

  // Place a finished candidate in the sorted list; higher score, then smaller rank, wins.
  function automatic void insert_candidate(logic signed [SCORE_W-1:0] s, logic [POS_W-1:0] p,
                                           logic [POS_W-1:0] r);
    int at;
    bit wins;
    at = 0;
    wins = 1'b0;
    while (at < top_fill && !wins) begin
      if (s != top_score[at]) wins = s > top_score[at];
      else wins = r < top_rank[at];
      if (!wins) at++;
    end
    if (at >= TOP_K) return;
    if (top_fill < TOP_K) top_fill++;
    for (int j = top_fill - 1; j > at; j--) begin
      top_score[j] = top_score[j-1];
      top_pos[j] = top_pos[j-1];
      top_rank[j] = top_rank[j-1];
    end
    top_score[at] = s;
    top_pos[at] = p;
    top_rank[at] = r;
  endfunction

  // Work out what one accepted item does and queue any rankings it releases.
  function automatic void predict_ranking(elem_item_t it);
    longint total;
    ranked_t res;
    total = longint'(run_sum) + longint'(it.doc) * longint'(it.query);
    if (total > longint'(SCORE_MAX)) total = longint'(SCORE_MAX);
    if (total < longint'(SCORE_MIN)) total = longint'(SCORE_MIN);
    run_sum = SCORE_W'(total);
    if (!it.last_dim) return;
    if ({1'b0, it.pos} >= doc_limit) pool_error = 1'b1;
    else insert_candidate(run_sum, it.pos, it.rank);
    run_sum = '0;
    if (!it.last_cand) return;
    pools_closed++;
    if (pool_error) begin
      pools_bad++;
      res.pos = '0;
      res.place = '0;
      res.last = 1'b1;
      res.bad = 1'b1;
      ranks_due.insert(ranks_due.size(), res);
    end else begin
      for (int i = 0; i < top_fill; i++) begin
        res.pos = top_pos[i];
        res.place = PLACE_W'(i);
        res.last = (i == top_fill - 1);
        res.bad = 1'b0;
        ranks_due.insert(ranks_due.size(), res);
      end
    end
    clear_pool();
  endfunction

  // Length of the next idle stretch: mostly none or short, a few long, with calm runs.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      calm = $urandom_range(50, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(20, 5);
  endfunction

  // Driver: presents pending items, holds them while stalled, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cand_valid && !cand_stall) begin
        predict_ranking(bus_item);
        items_taken++;
      end
      if (!cand_valid || !cand_stall) begin
        if (send_gap > 0) begin
          cand_valid <= 1'b0;
          send_gap--;
        end else if (pending.size() != 0) begin
          bus_item = pending.pop_front();
          doc_element <= bus_item.doc;
          query_element <= bus_item.query;
          candidate_position <= bus_item.pos;
          tie_rank <= bus_item.rank;
          last_dimension <= bus_item.last_dim;
          last_candidate <= bus_item.last_cand;
          cand_valid <= 1'b1;
          send_gap = idle_len(calm_send);
        end else begin
          cand_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks each accepted item.
  always @(posedge clk) begin
    ranked_t want;
    if (rst) begin
      rank_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rank_valid && !rank_stall) begin
        if (ranks_due.size() == 0) begin
          $error("unexpected ranking result: ranked_position %0d place %0d",
                 ranked_position, place);
          errors++;
        end else begin
          want = ranks_due.pop_front();
          results_checked++;
          if (ranked_position !== want.pos) begin
            $error("ranked_position: expected %0d, got %0d", want.pos, ranked_position);
            errors++;
          end
          if (place !== want.place) begin
            $error("place: expected %0d, got %0d", want.place, place);
            errors++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, is_last);
            errors++;
          end
          if (bad_position !== want.bad) begin
            $error("bad_position: expected %0d, got %0d", want.bad, bad_position);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        rank_stall <= 1'b1;
        stall_left--;
      end else begin
        rank_stall <= 1'b0;
        stall_left = idle_len(calm_recv);
      end
    end
  end

  task automatic queue_item(logic signed [ELEM_W-1:0] d, logic signed [ELEM_W-1:0] q,
                            logic [POS_W-1:0] p, logic [POS_W-1:0] r, logic ld, logic lc);
    elem_item_t it;
    it.doc = d;
    it.query = q;
    it.pos = p;
    it.rank = r;
    it.last_dim = ld;
    it.last_cand = lc;
    pending.insert(pending.size(), it);
    items_queued++;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_element(int mode);
    case (mode)
      0: return ELEM_W'($urandom);
      1: return ELEM_W'($urandom_range(4) - 2);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  // Positions mostly inside the document count, a share of them outside when asked.
  function automatic logic [POS_W-1:0] pick_position(int bad_pct);
    if (doc_limit == 0 || doc_limit > 25'hff_ffff) return POS_W'($urandom);
    if ($urandom_range(99) < bad_pct) return POS_W'($urandom_range(32'hff_ffff, doc_limit));
    return POS_W'($urandom_range(doc_limit - 1, 0));
  endfunction

  // One candidate vector: noise on the fields that only count on the last element.
  task automatic queue_candidate(int bad_pct, bit pool_end);
    int len;
    int mode;
    int r;
    logic [POS_W-1:0] rank;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(3, 1);
    else if (r < 95) len = $urandom_range(8, 4);
    else len = $urandom_range(24, 9);
    mode = $urandom_range(2);
    rank = ($urandom_range(1) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(3));
    for (int i = 0; i < len - 1; i++)
      queue_item(pick_element(mode), pick_element(mode), POS_W'($urandom), POS_W'($urandom),
                 1'b0, $urandom_range(4) == 0);
    queue_item(pick_element(mode), pick_element(mode), pick_position(bad_pct), rank, 1'b1,
               pool_end);
  endtask

  // Random pools until the item budget is spent.
  task automatic queue_pools(int budget);
    int start;
    int n;
    int r;
    int bad_pct;
    start = items_queued;
    while (items_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < 40) n = $urandom_range(5, 1);
      else if (r < 80) n = $urandom_range(11, 6);
      else n = $urandom_range(16, 12);
      bad_pct = ($urandom_range(3) == 0) ? 20 : 0;
      for (int c = 0; c < n; c++) queue_candidate(bad_pct, c == n - 1);
    end
  endtask

  // Wait until every item is taken and every ranking delivered, then let the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    while ((items_taken != items_queued || ranks_due.size() != 0) && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 200000) begin
      $error("ranking results still outstanding: %0d", ranks_due.size());
      errors++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_doc_count(logic [DOC_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    doc_limit = v;
    config_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: directed pools, then random pools over several counts.
  initial begin
    clear_pool();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the fields, ties on score and rank, and noise flags.
    queue_item(16'sh8000, 16'sh8000, 24'h00_0000, 24'hff_ffff, 1'b1, 1'b0);
    queue_item(16'sh7fff, 16'sh7fff, 24'd123, 24'd456, 1'b0, 1'b1);
    queue_item(16'sh8000, 16'sh7fff, 24'hff_ffff, 24'h00_0000, 1'b1, 1'b0);
    queue_item(16'sh0000, 16'sh0000, 24'd5, 24'd9, 1'b1, 1'b0);
    queue_item(16'sh0001, 16'sh0000, 24'd6, 24'd9, 1'b1, 1'b0);
    queue_item(16'sh0000, 16'sh8000, 24'd7, 24'd8, 1'b1, 1'b0);
    queue_item(16'sh0001, 16'sh0001, 24'h55_5555, 24'haa_aaaa, 1'b1, 1'b0);
    queue_item(16'shffff, 16'sh0001, 24'haa_aaaa, 24'h55_5555, 1'b1, 1'b1);

    // Full list: a weaker candidate and a full tie with the worst are dropped.
    for (int k = 1; k <= 10; k++)
      queue_item(ELEM_W'(k * 100), 16'sh0001, POS_W'(10 + k), POS_W'(k), 1'b1, 1'b0);
    queue_item(16'sd50, 16'sh0001, 24'd30, 24'd0, 1'b1, 1'b0);
    queue_item(16'sd100, 16'sh0001, 24'd33, 24'd1, 1'b1, 1'b0);
    queue_item(16'sd5000, 16'sh0001, 24'd31, 24'd0, 1'b1, 1'b1);
    drain();

    // Zero count turns every position bad.
    write_doc_count('0);
    queue_pools(25);
    drain();
    write_doc_count(25'd1);
    queue_pools(35);
    drain();
    write_doc_count(DOC_COUNT_RESET);
    queue_pools(70);
    drain();
    write_doc_count(DOC_W'($urandom_range(5000, 2)));
    queue_pools(50);
    drain();
    write_doc_count(25'h1ff_ffff);
    queue_pools(25);
    drain();
    write_doc_count(DOC_W'($urandom_range(32'h100_0000, 1)));
    queue_pools(25);
    drain();

    $display("Run covered %0d input items over %0d document count settings.",
             items_taken, config_writes + 1);
    $display("%0d pools closed, %0d with a bad position; %0d ranking results checked.",
             pools_closed, pools_bad, results_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rrk_pkg.sv
hdl/rrk_cell.sv
hdl/rrk_out_cell.sv
hdl/dot_product_top_k_rerank.sv
hdl/rrk_checker.sv
sim/tb_top.sv
